// ===== src/mfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types, codes and the CRC-16/MODBUS byte fold for the message
// fragmenter.
// ----------------------------------------------------------------------------
package mfc_pkg;

    localparam int LEN_BITS_DEF = 32;

    localparam logic [15:0] MAX_FRAG_RESET = 16'd1008;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic [1:0] RK_ACCEPT = 2'd0;
    localparam logic [1:0] RK_BYTE   = 2'd1;
    localparam logic [1:0] RK_HEADER = 2'd2;
    localparam logic [1:0] RK_ERROR  = 2'd3;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [7:0]  out_byte;
        logic [31:0] message_id;
        logic [15:0] frag_number;
        logic [15:0] frag_count;
        logic [15:0] frag_bytes;
        logic [31:0] message_bytes;
        logic [15:0] frag_crc;
        logic        last;
    } t_rec;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/mfc_if.sv =====
// ----------------------------------------------------------------------------
// mfc_in_if / mfc_out_if
// Valid/ready channels for the input items and the result records.
// ----------------------------------------------------------------------------
interface mfc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] msg_len;
    logic [7:0]  data_byte;

    modport source (output valid, kind, msg_len, data_byte, input ready);
    modport sink   (input valid, kind, msg_len, data_byte, output ready);
endinterface

interface mfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  rec_kind;
    logic [7:0]  out_byte;
    logic [31:0] message_id;
    logic [15:0] frag_number;
    logic [15:0] frag_count;
    logic [15:0] frag_bytes;
    logic [31:0] message_bytes;
    logic [15:0] frag_crc;
    logic        last;

    modport source (output valid, rec_kind, out_byte, message_id, frag_number,
                    frag_count, frag_bytes, message_bytes, frag_crc, last,
                    input ready);
    modport sink   (input valid, rec_kind, out_byte, message_id, frag_number,
                    frag_count, frag_bytes, message_bytes, frag_crc, last,
                    output ready);
endinterface

// ===== src/mfc_div.sv =====
// ----------------------------------------------------------------------------
// mfc_div
// Restoring divider, one quotient bit per cycle, keeping the low 16
// quotient bits.
// ----------------------------------------------------------------------------
module mfc_div #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [15:0]  i_divisor,
    output logic         o_done,
    output logic [15:0]  o_quot
);

    localparam int CW = $clog2(W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_dvd, n_dvd;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_div, n_div;
    logic [15:0]   r_quot, n_quot;
    logic [16:0]   trial;
    logic [16:0]   diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        trial  = {r_rem, r_dvd[W-1]};
        diff   = trial - {1'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_quot = '0;
        end else if (r_busy) begin
            n_dvd = r_dvd << 1;
            if (!diff[16]) begin
                n_rem  = diff[15:0];
                n_quot = {r_quot[14:0], 1'b1};
            end else begin
                n_rem  = trial[15:0];
                n_quot = {r_quot[14:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/message_fragmenter_crc16.sv =====
// ----------------------------------------------------------------------------
// message_fragmenter_crc16
// Splits messages into fragments, passes payload bytes through and emits a
// header record with a CRC-16/MODBUS after the last byte of each fragment.
//
//   Channel  Dir  Handshake      Transaction
//   i_in     in   valid/ready    start of message (length) or one data byte
//   o_rec    out  valid/ready    accept, payload byte, header or error record
//   i_cfg    in   write enable   fragment size limit, no read-back
//
// A data byte of an open message yields a payload record; a byte that ends a
// fragment also queues a header record, and the next transaction waits until
// it has been taken. The fragment count of a valid start is computed by the
// bit-serial divider. Errors yield an error record.
// Reset is synchronous and active low. A stalled output holds its record.
// ----------------------------------------------------------------------------
module message_fragmenter_crc16
    import mfc_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mfc_in_if.sink      i_in,
    mfc_out_if.source   o_rec
);

    localparam int DW = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                r_state, n_state;
    logic [15:0]         r_max;
    logic                r_busy, n_busy;
    logic [31:0]         r_id_cnt, n_id_cnt;
    logic [31:0]         r_cur_id, n_cur_id;
    logic [15:0]         r_crc, n_crc;
    logic [15:0]         r_frag_idx, n_frag_idx;
    logic [15:0]         r_frag_total, n_frag_total;
    logic [15:0]         r_bif, n_bif;
    logic [LEN_BITS-1:0] r_left, n_left;
    logic [LEN_BITS-1:0] r_total, n_total;
    logic [LEN_BITS-1:0] r_len, n_len;
    t_rec                r_out, n_out;
    logic                r_out_vld, n_out_vld;
    t_rec                r_hdr, n_hdr;
    logic                r_hdr_vld, n_hdr_vld;

    logic                in_ready;
    logic                in_fire;
    logic                out_take;
    logic                div_start;
    logic                div_done;
    logic [15:0]         div_quot;
    logic [DW-1:0]       dividend;
    logic                len_bad;
    logic [15:0]         crc_nx;
    logic [15:0]         bif_nx;
    logic [LEN_BITS-1:0] left_nx;
    logic                frag_end;
    t_rec                err_rec;

    mfc_div #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_max),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign out_take = r_out_vld && o_rec.ready;
    assign in_ready = (r_state == ST_IDLE) && !r_hdr_vld && (!r_out_vld || out_take);
    assign in_fire  = i_in.valid && in_ready;
    assign len_bad  = (i_in.msg_len == '0) || ((i_in.msg_len >> LEN_BITS) != '0)
                      || (r_max == '0);
    assign dividend = DW'(i_in.msg_len[LEN_BITS-1:0]) + DW'(r_max) - DW'(1);
    assign crc_nx   = crc_fold(r_crc, i_in.data_byte);
    assign bif_nx   = r_bif + 16'd1;
    assign left_nx  = r_left - LEN_BITS'(1);
    assign frag_end = (left_nx == '0) || (bif_nx >= r_max);

    always_comb begin
        err_rec          = '0;
        err_rec.rec_kind = RK_ERROR;
        err_rec.last     = 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_id_cnt     = r_id_cnt;
        n_cur_id     = r_cur_id;
        n_crc        = r_crc;
        n_frag_idx   = r_frag_idx;
        n_frag_total = r_frag_total;
        n_bif        = r_bif;
        n_left       = r_left;
        n_total      = r_total;
        n_len        = r_len;
        n_out        = r_out;
        n_out_vld    = r_out_vld;
        n_hdr        = r_hdr;
        n_hdr_vld    = r_hdr_vld;
        div_start    = 1'b0;

        if (out_take) begin
            if (r_hdr_vld) begin
                n_out     = r_hdr;
                n_hdr_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end

        if (in_fire) begin
            if (i_in.kind == KIND_START) begin
                if (len_bad) begin
                    n_out     = err_rec;
                    n_out_vld = 1'b1;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                    n_len     = i_in.msg_len[LEN_BITS-1:0];
                end
            end else if (!r_busy) begin
                n_out     = err_rec;
                n_out_vld = 1'b1;
            end else begin
                n_out               = '0;
                n_out.rec_kind      = RK_BYTE;
                n_out.out_byte      = i_in.data_byte;
                n_out.message_id    = r_cur_id;
                n_out.frag_number   = r_frag_idx;
                n_out.frag_count    = r_frag_total;
                n_out.message_bytes = 32'(r_total);
                n_out.last          = !frag_end;
                n_out_vld           = 1'b1;
                n_left              = left_nx;
                if (frag_end) begin
                    n_hdr               = '0;
                    n_hdr.rec_kind      = RK_HEADER;
                    n_hdr.message_id    = r_cur_id;
                    n_hdr.frag_number   = r_frag_idx;
                    n_hdr.frag_count    = r_frag_total;
                    n_hdr.frag_bytes    = bif_nx;
                    n_hdr.message_bytes = 32'(r_total);
                    n_hdr.frag_crc      = crc_nx;
                    n_hdr.last          = 1'b1;
                    n_hdr_vld           = 1'b1;
                    n_frag_idx          = r_frag_idx + 16'd1;
                    n_bif               = '0;
                    n_crc               = CRC_INIT;
                    n_busy              = (left_nx != '0);
                end else begin
                    n_bif = bif_nx;
                    n_crc = crc_nx;
                end
            end
        end

        if ((r_state == ST_DIV) && div_done) begin
            n_state             = ST_IDLE;
            n_busy              = 1'b1;
            n_cur_id            = r_id_cnt;
            n_id_cnt            = r_id_cnt + 32'd1;
            n_frag_total        = div_quot;
            n_frag_idx          = '0;
            n_bif               = '0;
            n_crc               = CRC_INIT;
            n_total             = r_len;
            n_left              = r_len;
            n_out               = '0;
            n_out.rec_kind      = RK_ACCEPT;
            n_out.message_id    = r_id_cnt;
            n_out.frag_count    = div_quot;
            n_out.message_bytes = 32'(r_len);
            n_out.last          = 1'b1;
            n_out_vld           = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max        <= MAX_FRAG_RESET;
            r_busy       <= 1'b0;
            r_id_cnt     <= '0;
            r_cur_id     <= '0;
            r_crc        <= CRC_INIT;
            r_frag_idx   <= '0;
            r_frag_total <= '0;
            r_bif        <= '0;
            r_left       <= '0;
            r_total      <= '0;
            r_out_vld    <= 1'b0;
            r_hdr_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_busy       <= n_busy;
            r_id_cnt     <= n_id_cnt;
            r_cur_id     <= n_cur_id;
            r_crc        <= n_crc;
            r_frag_idx   <= n_frag_idx;
            r_frag_total <= n_frag_total;
            r_bif        <= n_bif;
            r_left       <= n_left;
            r_total      <= n_total;
            r_out_vld    <= n_out_vld;
            r_hdr_vld    <= n_hdr_vld;
        end
        r_len <= n_len;
        r_out <= n_out;
        r_hdr <= n_hdr;
    end

    assign i_in.ready          = in_ready;
    assign o_rec.valid         = r_out_vld;
    assign o_rec.rec_kind      = r_out.rec_kind;
    assign o_rec.out_byte      = r_out.out_byte;
    assign o_rec.message_id    = r_out.message_id;
    assign o_rec.frag_number   = r_out.frag_number;
    assign o_rec.frag_count    = r_out.frag_count;
    assign o_rec.frag_bytes    = r_out.frag_bytes;
    assign o_rec.message_bytes = r_out.message_bytes;
    assign o_rec.frag_crc      = r_out.frag_crc;
    assign o_rec.last          = r_out.last;

    a_hdr_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_vld |-> r_out_vld)
        else $error("Header record queued without an output record ahead of it.");

    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !in_ready)
        else $error("Input accepted while the fragment count is being computed.");

    a_byte_then_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.rec_kind == RK_BYTE) && !r_out.last) |-> r_hdr_vld)
        else $error("Fragment-ending byte is not followed by a header record.");

    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("Message is open with no bytes left.");

endmodule
